/* hw/rtl/ghs_pkg.sv */
// ----------------------------------------------------------------------------
// ghs_pkg
// Shared types, constants and the kernel weight table of the heatmap splatter.
// ----------------------------------------------------------------------------
package ghs_pkg;

    localparam int HEATMAP_SIZE  = 32;
    localparam int KERNEL_RADIUS = 3;
    localparam int NUM_PLANES    = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam int FIELD_W   = 5;
    localparam int WEIGHT_W  = 16;
    localparam int COORD_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;
    localparam int PIX_W     = $clog2(HEATMAP_SIZE);
    localparam int IDX_W     = $clog2(HEATMAP_SIZE + KERNEL_RADIUS + 1) + 1;
    localparam int OFF_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COORD_SCALE   = CFG_IDX_W'(1);

    localparam logic signed [CFG_W-1:0] CENTER_OFFSET_RST = 16'sd6144;
    localparam logic [CFG_W-1:0]        COORD_SCALE_RST   = 16'd2645;

    // exp(-0.5*(dr^2+dc^2)) in Q0.16, indexed [|dr|][|dc|]
    localparam logic [WEIGHT_W-1:0] GAUSS_ROM [4][4] = '{
        '{16'd65535, 16'd39750, 16'd8869, 16'd728},
        '{16'd39750, 16'd24109, 16'd5380, 16'd442},
        '{16'd8869,  16'd5380,  16'd1200, 16'd99},
        '{16'd728,   16'd442,   16'd99,   16'd8}
    };

    typedef struct packed {
        logic [FIELD_W-1:0]        channel;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  plane;
        logic [FIELD_W-1:0]  row;
        logic [FIELD_W-1:0]  column;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]      plane;
        logic signed [IDX_W-1:0] ctr_col;
        logic signed [IDX_W-1:0] ctr_row;
        logic [PIX_W-1:0]        col_lo;
        logic [PIX_W-1:0]        col_hi;
        logic [PIX_W-1:0]        row_lo;
        logic [PIX_W-1:0]        row_hi;
    } qentry_t;

endpackage

/* hw/rtl/ghs_front.sv */
// ----------------------------------------------------------------------------
// ghs_front
// Config registers, coordinate mapping and tap window bounds. Items whose
// window is empty are dropped here.
// ----------------------------------------------------------------------------
module ghs_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [ghs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ghs_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ghs_pkg::in_item_t              s_data,
    output logic                           push,
    output ghs_pkg::qentry_t               push_data,
    input  logic                           q_full
);

    localparam int PROD_W = 2 * (ghs_pkg::COORD_W + 1);
    localparam int FRAC   = 20;
    localparam int IDX_W  = ghs_pkg::IDX_W;
    localparam int PIX_W  = ghs_pkg::PIX_W;

    localparam logic signed [PROD_W-1:0] HALF_C = PROD_W'(1 << (FRAC - 1));
    localparam logic signed [PROD_W-1:0] LO_C   = PROD_W'(-(ghs_pkg::KERNEL_RADIUS + 1));
    localparam logic signed [PROD_W-1:0] HI_C   =
        PROD_W'(ghs_pkg::HEATMAP_SIZE + ghs_pkg::KERNEL_RADIUS);
    localparam logic signed [IDX_W:0] RAD_C    = (IDX_W+1)'(ghs_pkg::KERNEL_RADIUS);
    localparam logic signed [IDX_W:0] SIZE_M1_C = (IDX_W+1)'(ghs_pkg::HEATMAP_SIZE - 1);

    function automatic logic signed [IDX_W-1:0] map_index(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        logic signed [PROD_W-1:0] r;
        // half away from zero: floor((p + half - sign) / 2^FRAC)
        t = p + HALF_C - {{(PROD_W-1){1'b0}}, p[PROD_W-1]};
        r = t >>> FRAC;
        if (r < LO_C) begin
            r = LO_C;
        end else if (r > HI_C) begin
            r = HI_C;
        end
        return IDX_W'(r);
    endfunction

    logic signed [ghs_pkg::CFG_W-1:0] center_offset_reg;
    logic [ghs_pkg::CFG_W-1:0]        coord_scale_reg;

    logic                              v1_reg;
    logic [ghs_pkg::FIELD_W-1:0]       plane1_reg;
    logic signed [PROD_W-1:0]          prod_x_reg;
    logic signed [PROD_W-1:0]          prod_y_reg;

    logic                              v2_reg;
    logic [ghs_pkg::FIELD_W-1:0]       plane2_reg;
    logic signed [IDX_W-1:0]           ctr_col_reg;
    logic signed [IDX_W-1:0]           ctr_row_reg;

    logic signed [ghs_pkg::COORD_W:0]  sum_x;
    logic signed [ghs_pkg::COORD_W:0]  sum_y;
    logic signed [ghs_pkg::COORD_W:0]  scale_s;
    logic signed [PROD_W-1:0]          prod_x_next;
    logic signed [PROD_W-1:0]          prod_y_next;

    logic signed [IDX_W:0]             c_lo_s, c_hi_s, r_lo_s, r_hi_s;
    logic                              keep;
    logic                              done2, en2, en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_offset_reg <= ghs_pkg::CENTER_OFFSET_RST;
            coord_scale_reg   <= ghs_pkg::COORD_SCALE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ghs_pkg::REG_CENTER_OFFSET: center_offset_reg <= cfg_data;
                ghs_pkg::REG_COORD_SCALE:   coord_scale_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sum_x       = (ghs_pkg::COORD_W+1)'(s_data.x_coord)
                    + (ghs_pkg::COORD_W+1)'(center_offset_reg);
        sum_y       = (ghs_pkg::COORD_W+1)'(s_data.y_coord)
                    + (ghs_pkg::COORD_W+1)'(center_offset_reg);
        scale_s     = $signed({1'b0, coord_scale_reg});
        prod_x_next = sum_x * scale_s;
        prod_y_next = sum_y * scale_s;
    end

    always_comb begin
        c_lo_s = (IDX_W+1)'(ctr_col_reg) - RAD_C;
        c_hi_s = (IDX_W+1)'(ctr_col_reg) + RAD_C;
        r_lo_s = (IDX_W+1)'(ctr_row_reg) - RAD_C;
        r_hi_s = (IDX_W+1)'(ctr_row_reg) + RAD_C;
        keep   = (int'(plane2_reg) < ghs_pkg::NUM_PLANES)
              && !(c_hi_s < 0) && !(c_lo_s > SIZE_M1_C)
              && !(r_hi_s < 0) && !(r_lo_s > SIZE_M1_C);

        push_data.plane   = plane2_reg;
        push_data.ctr_col = ctr_col_reg;
        push_data.ctr_row = ctr_row_reg;
        push_data.col_lo  = (c_lo_s < 0) ? '0 : PIX_W'(c_lo_s);
        push_data.col_hi  = (c_hi_s > SIZE_M1_C) ? PIX_W'(SIZE_M1_C) : PIX_W'(c_hi_s);
        push_data.row_lo  = (r_lo_s < 0) ? '0 : PIX_W'(r_lo_s);
        push_data.row_hi  = (r_hi_s > SIZE_M1_C) ? PIX_W'(SIZE_M1_C) : PIX_W'(r_hi_s);
    end

    assign push    = v2_reg && keep && !q_full;
    assign done2   = v2_reg && (!keep || !q_full);
    assign en2     = !v2_reg || done2;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            plane1_reg <= s_data.channel;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (en2) begin
            plane2_reg  <= plane1_reg;
            ctr_col_reg <= map_index(prod_x_reg);
            ctr_row_reg <= map_index(prod_y_reg);
        end
    end

endmodule

/* hw/rtl/ghs_queue.sv */
// ----------------------------------------------------------------------------
// ghs_queue
// Short request queue between the mapping front end and the tap scanner.
// ----------------------------------------------------------------------------
module ghs_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ghs_pkg::qentry_t push_data,
    output logic             full,
    input  logic             pop,
    output ghs_pkg::qentry_t pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(ghs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ghs_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ghs_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(ghs_pkg::QUEUE_DEPTH);

    ghs_pkg::qentry_t   slot_reg [ghs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue pop while empty");

endmodule

/* hw/rtl/ghs_back.sv */
// ----------------------------------------------------------------------------
// ghs_back
// Tap scanner: walks the clipped window column outer, row inner, one pixel
// write per cycle into the output register while m_ready does not stall it.
// ----------------------------------------------------------------------------
module ghs_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  ghs_pkg::qentry_t   q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ghs_pkg::out_item_t m_data
);

    localparam int IDX_W = ghs_pkg::IDX_W;
    localparam int PIX_W = ghs_pkg::PIX_W;
    localparam int OFF_W = ghs_pkg::OFF_W;

    ghs_pkg::qentry_t          entry_reg;
    logic                      active_reg;
    logic [PIX_W-1:0]          col_reg, row_reg;
    logic [PIX_W-1:0]          col_next, row_next;
    logic                      m_valid_reg;
    ghs_pkg::out_item_t        m_data_reg, m_data_next;

    logic                      out_adv, produce, last, load;
    logic signed [IDX_W:0]     dc_s, dr_s;
    logic [OFF_W-1:0]          dc_abs, dr_abs;

    assign out_adv = !m_valid_reg || m_ready;
    assign produce = active_reg && out_adv;
    assign last    = (col_reg == entry_reg.col_hi) && (row_reg == entry_reg.row_hi);
    assign load    = (!active_reg || (produce && last)) && !q_empty;
    assign pop     = load;

    always_comb begin
        dc_s   = (IDX_W+1)'($signed({1'b0, col_reg})) - (IDX_W+1)'(entry_reg.ctr_col);
        dr_s   = (IDX_W+1)'($signed({1'b0, row_reg})) - (IDX_W+1)'(entry_reg.ctr_row);
        dc_abs = (dc_s < 0) ? OFF_W'(-dc_s) : OFF_W'(dc_s);
        dr_abs = (dr_s < 0) ? OFF_W'(-dr_s) : OFF_W'(dr_s);

        m_data_next.plane  = entry_reg.plane;
        m_data_next.row    = ghs_pkg::FIELD_W'(row_reg);
        m_data_next.column = ghs_pkg::FIELD_W'(col_reg);
        m_data_next.weight = ghs_pkg::GAUSS_ROM[dr_abs][dc_abs];
        m_data_next.last   = last;

        if (row_reg == entry_reg.row_hi) begin
            row_next = entry_reg.row_lo;
            col_next = col_reg + 1'b1;
        end else begin
            row_next = row_reg + 1'b1;
            col_next = col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                active_reg <= 1'b1;
            end else if (produce && last) begin
                active_reg <= 1'b0;
            end
            if (produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= q_data;
            col_reg   <= q_data.col_lo;
            row_reg   <= q_data.row_lo;
        end else if (produce) begin
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
        if (produce) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_scan_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (row_reg >= entry_reg.row_lo) && (row_reg <= entry_reg.row_hi)
                    && (col_reg >= entry_reg.col_lo) && (col_reg <= entry_reg.col_hi))
        else $error("scan left its window");
    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && last && q_empty) |=> !active_reg)
        else $error("scanner stayed busy after last write");
    a_last_out_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        produce |=> m_valid_reg && (m_data_reg.last == $past(last)))
        else $error("last marker lost");

endmodule

/* hw/rtl/gaussian_heatmap_splat.sv */
// ----------------------------------------------------------------------------
// gaussian_heatmap_splat
// Throughput: one pixel write per cycle while m_ready does not stall; a keypoint
// holds the scanner for one write per in-map tap (up to 49), walked by the
// column and row scan counters.
// Keypoints with no in-map taps are dropped in the front end and skip the scanner.
// Reset: synchronous active low; registers return to defaults, queue empties.
// ----------------------------------------------------------------------------
module gaussian_heatmap_splat (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ghs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ghs_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ghs_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ghs_pkg::out_item_t             m_data
);

    logic             push, q_full, pop, q_empty;
    ghs_pkg::qentry_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    ghs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    ghs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    ghs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* tb/ghs_splat_checker.sv */
// ----------------------------------------------------------------------------
// ghs_splat_checker
// Watches the register, keypoint and pixel-write channels of the heatmap
// splatter, predicts each pixel write, and reports mismatches.
// ----------------------------------------------------------------------------
module ghs_splat_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ghs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ghs_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  ghs_pkg::in_item_t             s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  ghs_pkg::out_item_t            m_data,
    output int                            pending,
    output int                            fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ghs_pkg::*;

    localparam int MAP_DIM         = 32;
    localparam int REACH           = 3;
    localparam int PLANES          = 32;
    localparam int OFFSET_AT_RESET = 6144;
    localparam int SCALE_AT_RESET  = 2645;

    int        offset_q;
    int        scale_q;
    int        fails;
    out_item_t pixel_writes_due[$];

    initial begin
        pending    = 0;
        fail_count = 0;
        fails      = 0;
    end

    function automatic logic [WEIGHT_W-1:0] gauss_q16(input int dist2);
        real w;
        w = $exp(-0.5 * dist2) * 65536.0;
        if (w > 65535.0) begin
            w = 65535.0;
        end
        return WEIGHT_W'($rtoi(w + 0.5));
    endfunction

    // round half away from zero, then clamp just outside the kernel reach
    function automatic int keypoint_pixel(input logic signed [COORD_W-1:0] coord);
        int     c;
        longint prod;
        longint mag;
        longint r;
        c    = coord;
        prod = longint'(c + offset_q) * longint'(scale_q);
        mag  = (prod < 0) ? -prod : prod;
        r    = (mag + 64'sd524288) >>> 20;
        if (prod < 0) begin
            r = -r;
        end
        if (r < -REACH - 1) begin
            r = -REACH - 1;
        end
        if (r > MAP_DIM + REACH) begin
            r = MAP_DIM + REACH;
        end
        return int'(r);
    endfunction

    function automatic void splat_keypoint(input in_item_t kp);
        int        col_c;
        int        row_c;
        int        first;
        out_item_t px;
        col_c = keypoint_pixel(kp.x_coord);
        row_c = keypoint_pixel(kp.y_coord);
        first = pixel_writes_due.size();
        if (int'(kp.channel) >= PLANES) begin
            return;
        end
        for (int dc = -REACH; dc <= REACH; dc++) begin
            if (col_c + dc < 0 || col_c + dc >= MAP_DIM) begin
                continue;
            end
            for (int dr = -REACH; dr <= REACH; dr++) begin
                if (row_c + dr < 0 || row_c + dr >= MAP_DIM) begin
                    continue;
                end
                px.plane  = kp.channel;
                px.row    = FIELD_W'(row_c + dr);
                px.column = FIELD_W'(col_c + dc);
                px.weight = gauss_q16(dr * dr + dc * dc);
                px.last   = 1'b0;
                pixel_writes_due.push_back(px);
            end
        end
        if (pixel_writes_due.size() > first) begin
            pixel_writes_due[$].last = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            offset_q = OFFSET_AT_RESET;
            scale_q  = SCALE_AT_RESET;
            pixel_writes_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CENTER_OFFSET: begin
                        offset_q = $signed(cfg_data);
                    end
                    REG_COORD_SCALE: begin
                        scale_q = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                splat_keypoint(s_data);
            end
            if (m_valid && m_ready) begin
                if (pixel_writes_due.size() == 0) begin
                    $error("unexpected pixel write: plane %0d row %0d column %0d",
                           m_data.plane, m_data.row, m_data.column);
                    fails++;
                end else begin
                    want = pixel_writes_due.pop_front();
                    if (m_data.plane !== want.plane) begin
                        $error("plane: expected %0d, got %0d", want.plane, m_data.plane);
                        fails++;
                    end
                    if (m_data.row !== want.row) begin
                        $error("row: expected %0d, got %0d", want.row, m_data.row);
                        fails++;
                    end
                    if (m_data.column !== want.column) begin
                        $error("column: expected %0d, got %0d", want.column, m_data.column);
                        fails++;
                    end
                    if (m_data.weight !== want.weight) begin
                        $error("weight: expected %0d, got %0d", want.weight, m_data.weight);
                        fails++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_data.last);
                        fails++;
                    end
                end
            end
        end
        pending    <= pixel_writes_due.size();
        fail_count <= fails;
    end

endmodule

/* tb/tb_gaussian_heatmap_splat.sv */
// ----------------------------------------------------------------------------
// tb_gaussian_heatmap_splat
// Drives keypoints and register writes into the heatmap splatter under random
// idling and one long output stall; a checker beside the block scores every
// pixel write.
// ----------------------------------------------------------------------------
module tb_gaussian_heatmap_splat;
    timeunit 1ns;
    timeprecision 1ps;
    import ghs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_AT        = 1500;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 58;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    int outstanding;
    int mismatches;
    int stalled    = 0;
    int cur_offset = 6144;
    int cur_scale  = 2645;
    int s_sent     = 0;
    bit s_calm     = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    gaussian_heatmap_splat u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ghs_splat_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .pending    (outstanding),
        .fail_count (mismatches)
    );

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stalled <= 0;
        end else if (stalled >= WATCHDOG_LIMIT) begin
            $display("tb_gaussian_heatmap_splat: errors");
            $finish;
        end else begin
            stalled <= stalled + 1;
        end
    end

    // coordinate whose pixel index lands on target under the current registers
    function automatic logic [COORD_W-1:0] aim_coord(input int target, input bit jitter);
        longint want;
        if (cur_scale == 0) begin
            return COORD_W'($urandom);
        end
        want = longint'(target) * 64'sd1048576;
        if (jitter) begin
            want = want + longint'($urandom_range(0, 1048575)) - 64'sd524288;
        end
        want = want / cur_scale - cur_offset;
        if (want < -32768 || want > 32767) begin
            return COORD_W'($urandom);
        end
        return COORD_W'(want);
    endfunction

    function automatic int near_pixel();
        return int'($urandom_range(0, 41)) - 5;
    endfunction

    task automatic send_keypoint(input logic [FIELD_W-1:0] chan,
                                 input logic [COORD_W-1:0] xc,
                                 input logic [COORD_W-1:0] yc);
        int gap;
        gap = s_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data.channel <= chan;
        s_data.x_coord <= xc;
        s_data.y_coord <= yc;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        s_sent++;
        if (s_sent % 40 == 0) begin
            s_calm = ($urandom_range(0, 2) == 0);
        end
    endtask

    task automatic let_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_CENTER_OFFSET) begin
            cur_offset = $signed(val);
        end else if (idx == REG_COORD_SCALE) begin
            cur_scale = val;
        end
    endtask

    task automatic set_config(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] scl);
        let_drain();
        write_reg(REG_CENTER_OFFSET, off);
        write_reg(REG_COORD_SCALE, scl);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        fork
            begin : result_sink
                int gap;
                int taken;
                bit calm;
                taken = 0;
                calm  = 1'b0;
                forever begin
                    m_ready <= 1'b1;
                    do @(posedge aclk); while (!(m_valid && m_ready));
                    taken++;
                    if (taken % 50 == 0) begin
                        calm = ($urandom_range(0, 2) == 0);
                    end
                    gap = calm ? 0 : $urandom_range(0, 5);
                    if (taken == HOLD_AT) begin
                        gap = HOLD_CYCLES;
                    end
                    if (gap > 0) begin
                        m_ready <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end
            end
        join_none

        // registers at reset: centre, corners, kernel edges and far-off keypoints
        send_keypoint(5'd0, 16'sd0, 16'sd0);
        send_keypoint(5'd31, 16'sd6144, 16'sd6144);
        send_keypoint(5'd1, -16'sd6144, -16'sd6144);
        send_keypoint(5'd10, aim_coord(-3, 1'b0), aim_coord(34, 1'b0));
        send_keypoint(5'd21, aim_coord(-4, 1'b0), 16'sd0);
        send_keypoint(5'd2, 16'sd0, aim_coord(35, 1'b0));
        send_keypoint(5'd3, 16'sh7fff, 16'sd0);
        send_keypoint(5'd4, 16'sh8000, 16'sh8000);
        send_keypoint(5'd5, 16'sd0, 16'sh7fff);

        // scale 256 (4096 coordinate units per pixel), no offset: halves round away from zero
        set_config(16'd0, 16'd256);
        write_reg(REG_SPARE, 16'hffff);
        send_keypoint(5'd7, 16'sd2048, -16'sd2048);
        send_keypoint(5'd8, -16'sd2048, 16'sd2048);
        send_keypoint(5'd9, 16'sd2049, 16'sd2047);
        send_keypoint(5'd11, 16'sh7fff, 16'sh7fff);
        send_keypoint(5'd12, 16'sh8000, 16'sd0);

        // register extremes
        set_config(16'h8000, 16'hffff);
        send_keypoint(5'd13, 16'sh7fff, 16'sh7fff);
        send_keypoint(5'd14, 16'sh7fff, 16'sd32700);
        send_keypoint(5'd15, 16'sd0, 16'sd0);
        set_config(16'h7fff, 16'h0000);
        send_keypoint(5'd16, 16'sh8000, 16'sh7fff);
        send_keypoint(5'd17, 16'sd0, 16'sd0);
        set_config(16'h7fff, 16'hffff);
        send_keypoint(5'd18, 16'sh8000, -16'sd32751);
        send_keypoint(5'd19, 16'sd100, 16'sh8000);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                set_config(16'd6144, 16'd2645);
            end else if (ph % 2 == 1) begin
                set_config(CFG_W'($urandom_range(4096, 8192)),
                           CFG_W'($urandom_range(1800, 3600)));
            end else begin
                set_config(CFG_W'($urandom), CFG_W'($urandom));
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_keypoint(FIELD_W'($urandom), aim_coord(near_pixel(), 1'b1),
                                  aim_coord(near_pixel(), 1'b1));
                end else if ($urandom_range(0, 1) == 0) begin
                    send_keypoint(FIELD_W'($urandom), COORD_W'($urandom),
                                  aim_coord(near_pixel(), 1'b1));
                end else begin
                    send_keypoint(FIELD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
                end
            end
        end

        let_drain();
        if (mismatches == 0) begin
            $display("tb_gaussian_heatmap_splat: clean");
        end else begin
            $display("tb_gaussian_heatmap_splat: errors");
        end
        $finish;
    end

endmodule
